[sv/m4inv_pkg.sv]
// Package for the 4x4 fixed-point matrix inverse unit.
// Holds the shared widths, state and phase codes, the MAC item structs and the index helpers.
// Depends on nothing; every other file of the block uses it by scoped names.
package m4inv_pkg;

	localparam int ELEM_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int LIMB_W    = 33;
	localparam int PROD_W    = ELEM_W + LIMB_W;
	localparam int MINOR_W   = 2 * ELEM_W + 1;
	localparam int COF_W     = 100;
	localparam int CMAG_W    = 96;
	localparam int DET_W     = 131;
	localparam int DMAG_W    = DET_W - 1;
	localparam int ACC_W     = 132;
	localparam int QBITS     = ELEM_W + 2;
	localparam int DSH_W     = DMAG_W + QBITS;
	localparam int NUM_SH    = 2 * FRAC_BITS + 1;
	localparam int DRAIN_CYC = 5;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_MAC,
		ST_DRAIN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_MINOR,
		PH_COF,
		PH_DET
	} phase_t;

	typedef struct packed {
		phase_t     kind;
		logic [3:0] idx;
	} dst_t;

	typedef struct packed {
		logic              valid;
		logic [ELEM_W-1:0] x;
		logic [LIMB_W-1:0] y;
		logic [1:0]        limb;
		logic              neg;
		logic              last;
		dst_t              dst;
	} mac_op_t;

	typedef struct packed {
		logic             valid;
		dst_t             dst;
		logic [ACC_W-1:0] value;
	} mac_res_t;

	// Columns {c0, c1} of the 2x2 minor with the given column-pair index.
	function automatic logic [3:0] minor_cols(input logic [2:0] q);
		logic [3:0] r;
		unique case (q)
			3'd0:    r = {2'd0, 2'd1};
			3'd1:    r = {2'd0, 2'd2};
			3'd2:    r = {2'd0, 2'd3};
			3'd3:    r = {2'd1, 2'd2};
			3'd4:    r = {2'd1, 2'd3};
			default: r = {2'd2, 2'd3};
		endcase
		return r;
	endfunction

	// Column-pair index of columns a and b, with a below b.
	function automatic logic [2:0] pair_index(input logic [1:0] a, input logic [1:0] b);
		logic [2:0] r;
		if (a == 2'd0) begin
			r = {1'b0, b} - 3'd1;
		end else if (a == 2'd1) begin
			r = {1'b0, b} + 3'd1;
		end else begin
			r = 3'd5;
		end
		return r;
	endfunction

	// The j-th column left over when column c is struck out.
	function automatic logic [1:0] col_skip(input logic [1:0] c, input logic [1:0] j);
		logic [1:0] r;
		r = (j < c) ? j : j + 2'd1;
		return r;
	endfunction

endpackage

[sv/m4inv_mac.sv]
// Shared multiply-accumulate unit of the 4x4 matrix inverse unit.
// One 32x33 signed product per cycle, shifted by its limb and summed into a wide accumulator.
// Depends on m4inv_pkg.
module m4inv_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  m4inv_pkg::mac_op_t  op,
	output m4inv_pkg::mac_res_t res
);

	logic                                 valid_s2;
	logic signed [m4inv_pkg::PROD_W-1:0]  prod_s2;
	logic [1:0]                           limb_s2;
	logic                                 neg_s2;
	logic                                 last_s2;
	m4inv_pkg::dst_t                      dst_s2;
	logic [m4inv_pkg::ACC_W-1:0]          acc_q;
	logic [m4inv_pkg::ACC_W-1:0]          term;
	logic [m4inv_pkg::ACC_W-1:0]          sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(op.x) * $signed(op.y);
		limb_s2 <= op.limb;
		neg_s2  <= op.neg;
		last_s2 <= op.last;
		dst_s2  <= op.dst;
	end

	always_comb begin
		term = {{(m4inv_pkg::ACC_W - m4inv_pkg::PROD_W){prod_s2[m4inv_pkg::PROD_W-1]}}, prod_s2};
		term = term << {limb_s2, 5'b0};
		sum  = neg_s2 ? acc_q - term : acc_q + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			res   <= '0;
		end else begin
			res.valid <= valid_s2 && last_s2;
			res.dst   <= dst_s2;
			res.value <= sum;
			if (valid_s2) begin
				acc_q <= last_s2 ? '0 : sum;
			end
		end
	end

endmodule

[sv/m4inv_div.sv]
// Restoring divider of the 4x4 matrix inverse unit, one quotient bit per cycle.
// Forms round(|cofactor| * 2^32 / |det|) with ties away from zero, 34 quotient bits.
// Depends on m4inv_pkg.
module m4inv_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [m4inv_pkg::CMAG_W-1:0] num_mag,
	input  logic [m4inv_pkg::DMAG_W-1:0] den_mag,
	output logic                         done,
	output logic [m4inv_pkg::QBITS-1:0]  quot
);

	logic                         busy_q;
	logic [5:0]                   cnt_q;
	logic [m4inv_pkg::ACC_W-1:0]  r_q;
	logic [m4inv_pkg::DSH_W-1:0]  d_q;
	logic [m4inv_pkg::QBITS-1:0]  q_q;
	logic                         ge;

	assign ge   = m4inv_pkg::DSH_W'(r_q) >= d_q;
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(m4inv_pkg::QBITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= m4inv_pkg::ACC_W'({num_mag, {m4inv_pkg::NUM_SH{1'b0}}})
				+ m4inv_pkg::ACC_W'(den_mag);
			d_q <= m4inv_pkg::DSH_W'({den_mag, 1'b0}) << (m4inv_pkg::QBITS - 1);
			q_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				r_q <= r_q - d_q[m4inv_pkg::ACC_W-1:0];
			end
			q_q <= {q_q[m4inv_pkg::QBITS-2:0], ge};
			d_q <= d_q >> 1;
		end
	end

endmodule

[sv/matrix4_inverse_unit.sv]
// Top level of the 4x4 fixed-point matrix inverse unit: loading, sequencer and result register.
// Instantiates m4inv_mac and m4inv_div; depends on m4inv_pkg.
//
// The unit takes the 16 elements of a 4x4 Q16.16 matrix in row-major order, one item per cycle,
// and then returns the 16 elements of its inverse in row-major order, with last_element set on
// the sixteenth. Cofactors and the determinant are exact; each result is rounded to nearest,
// ties away from zero, and saturated. A zero determinant gives sixteen zero results with
// singular set. After the sixteenth element is taken, input stays stalled while one shared
// 32x33 multiplier runs 136 products (the 2x2 minors, the cofactors, the determinant) with
// three short drain gaps, and then a one-bit-per-cycle divider works out each result in turn;
// a singular matrix skips the divisions. A new matrix is taken only after the sixteenth result
// is loaded into the output register.
module matrix4_inverse_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [m4inv_pkg::ELEM_W-1:0] element_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [m4inv_pkg::ELEM_W-1:0] inverse_value,
	output logic                                singular,
	output logic                                last_element
);

	localparam logic [m4inv_pkg::QBITS-1:0] MAG_NEG_MAX =
		m4inv_pkg::QBITS'(1) << (m4inv_pkg::ELEM_W - 1);
	localparam logic [m4inv_pkg::QBITS-1:0] MAG_POS_MAX = MAG_NEG_MAX - m4inv_pkg::QBITS'(1);

	m4inv_pkg::state_t                 state_q, state_d;
	m4inv_pkg::phase_t                 phase_q;
	logic [3:0]                        load_cnt_q;
	logic [3:0]                        grp_q;
	logic [1:0]                        term_q;
	logic [1:0]                        limb_q;
	logic [2:0]                        drain_q;
	logic [3:0]                        k_q;
	logic                              neg_q;

	logic [m4inv_pkg::ELEM_W-1:0]      mat_a_q [16];
	logic [m4inv_pkg::ELEM_W-1:0]      mat_b_q [16];
	logic [m4inv_pkg::MINOR_W-1:0]     minor_q [12];
	logic [m4inv_pkg::COF_W-1:0]       cof_q   [16];
	logic [m4inv_pkg::DET_W-1:0]       det_q;

	logic                              out_valid_q;
	logic [m4inv_pkg::ELEM_W-1:0]      inverse_value_q;
	logic                              singular_q;
	logic                              last_q;

	m4inv_pkg::mac_op_t                op_s1;
	m4inv_pkg::mac_res_t               mac_res;

	logic                              issue;
	logic                              div_start;
	logic                              div_done;
	logic [m4inv_pkg::QBITS-1:0]       div_quot;
	logic                              out_free;
	logic                              out_load;
	logic                              det_zero;

	logic [3:0]                        xa;
	logic [3:0]                        ya;
	logic [3:0]                        mid;
	logic [m4inv_pkg::LIMB_W-1:0]      y_sel;
	logic                              op_neg;
	logic                              op_last;
	logic                              phase_end;
	logic [1:0]                        limb_max;
	logic [1:0]                        term_max;
	logic [3:0]                        grp_max;
	logic                              p_hi;
	logic [2:0]                        pq;
	logic [3:0]                        cols;
	logic [1:0]                        rr;
	logic [1:0]                        cc;
	logic [1:0]                        cj;
	logic [1:0]                        o0;
	logic [1:0]                        o1;
	logic [2:0]                        pr;
	logic [m4inv_pkg::MINOR_W-1:0]     minor_rd;
	logic [m4inv_pkg::COF_W-1:0]       cof_rd;

	logic [3:0]                        ci;
	logic [m4inv_pkg::COF_W-1:0]       cof_div;
	logic [m4inv_pkg::COF_W-1:0]       cof_abs;
	logic [m4inv_pkg::DET_W-1:0]       det_abs;
	logic [m4inv_pkg::QBITS-1:0]       mag_lim;
	logic [m4inv_pkg::QBITS-1:0]       mag;
	logic [m4inv_pkg::ELEM_W-1:0]      result;

	assign det_zero = (det_q == '0);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		xa       = '0;
		ya       = '0;
		mid      = '0;
		y_sel    = '0;
		op_neg   = 1'b0;
		op_last  = 1'b0;
		limb_max = 2'd0;
		term_max = 2'd0;
		grp_max  = 4'd0;
		p_hi     = grp_q >= 4'd6;
		pq       = p_hi ? 3'(grp_q - 4'd6) : grp_q[2:0];
		cols     = m4inv_pkg::minor_cols(pq);
		rr       = grp_q[3:2];
		cc       = grp_q[1:0];
		cj       = m4inv_pkg::col_skip(cc, term_q);
		o0       = m4inv_pkg::col_skip(cc, (term_q == 2'd0) ? 2'd1 : 2'd0);
		o1       = m4inv_pkg::col_skip(cc, (term_q == 2'd2) ? 2'd1 : 2'd2);
		pr       = m4inv_pkg::pair_index(o0, o1);
		minor_rd = '0;
		cof_rd   = '0;
		unique case (phase_q)
			m4inv_pkg::PH_MINOR: begin
				term_max = 2'd1;
				grp_max  = 4'd11;
				if (!term_q[0]) begin
					xa = {p_hi, 1'b0, cols[3:2]};
					ya = {p_hi, 1'b1, cols[1:0]};
				end else begin
					xa = {p_hi, 1'b0, cols[1:0]};
					ya = {p_hi, 1'b1, cols[3:2]};
				end
				y_sel   = {mat_b_q[ya][m4inv_pkg::ELEM_W-1], mat_b_q[ya]};
				op_neg  = term_q[0];
				op_last = term_q[0];
			end
			m4inv_pkg::PH_COF: begin
				limb_max = 2'd1;
				term_max = 2'd2;
				grp_max  = 4'd15;
				mid      = rr[1] ? {1'b0, pr} : 4'({1'b0, pr}) + 4'd6;
				xa       = {rr ^ 2'b01, cj};
				minor_rd = minor_q[mid];
				y_sel    = limb_q[0] ? minor_rd[m4inv_pkg::MINOR_W-1:32]
					: {1'b0, minor_rd[31:0]};
				op_neg   = rr[0] ^ cc[0] ^ term_q[0];
				op_last  = (term_q == 2'd2) && limb_q[0];
			end
			m4inv_pkg::PH_DET: begin
				limb_max = 2'd3;
				term_max = 2'd3;
				xa       = {2'b00, term_q};
				cof_rd   = cof_q[{2'b00, term_q}];
				unique case (limb_q)
					2'd0: y_sel = {1'b0, cof_rd[31:0]};
					2'd1: y_sel = {1'b0, cof_rd[63:32]};
					2'd2: y_sel = {1'b0, cof_rd[95:64]};
					default: y_sel = {{29{cof_rd[99]}}, cof_rd[99:96]};
				endcase
				op_last = (term_q == 2'd3) && (limb_q == 2'd3);
			end
			default: begin
				op_last = 1'b1;
			end
		endcase
		phase_end = op_last && (grp_q == grp_max);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			m4inv_pkg::ST_LOAD: begin
				if (in_valid && load_cnt_q == 4'd15) begin
					state_d = m4inv_pkg::ST_MAC;
				end
			end
			m4inv_pkg::ST_MAC: begin
				if (phase_end) begin
					state_d = m4inv_pkg::ST_DRAIN;
				end
			end
			m4inv_pkg::ST_DRAIN: begin
				if (drain_q == 3'd0) begin
					state_d = (phase_q == m4inv_pkg::PH_DET) ? m4inv_pkg::ST_DIV_START
						: m4inv_pkg::ST_MAC;
				end
			end
			m4inv_pkg::ST_DIV_START: begin
				state_d = det_zero ? m4inv_pkg::ST_EMIT : m4inv_pkg::ST_DIV_WAIT;
			end
			m4inv_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = m4inv_pkg::ST_EMIT;
				end
			end
			m4inv_pkg::ST_EMIT: begin
				if (out_free) begin
					if (k_q == 4'd15) begin
						state_d = m4inv_pkg::ST_LOAD;
					end else if (det_zero) begin
						state_d = m4inv_pkg::ST_EMIT;
					end else begin
						state_d = m4inv_pkg::ST_DIV_START;
					end
				end
			end
			default: state_d = m4inv_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != m4inv_pkg::ST_LOAD);
		issue     = (state_q == m4inv_pkg::ST_MAC);
		div_start = (state_q == m4inv_pkg::ST_DIV_START) && !det_zero;
		out_load  = (state_q == m4inv_pkg::ST_EMIT) && out_free;
	end

	always_comb begin
		ci      = {k_q[1:0], k_q[3:2]};
		cof_div = cof_q[ci];
		cof_abs = cof_div[m4inv_pkg::COF_W-1] ? m4inv_pkg::COF_W'(0) - cof_div : cof_div;
		det_abs = det_q[m4inv_pkg::DET_W-1] ? m4inv_pkg::DET_W'(0) - det_q : det_q;
		mag_lim = neg_q ? MAG_NEG_MAX : MAG_POS_MAX;
		mag     = (div_quot > mag_lim) ? mag_lim : div_quot;
		if (det_zero) begin
			result = '0;
		end else if (neg_q) begin
			result = m4inv_pkg::ELEM_W'(0) - mag[m4inv_pkg::ELEM_W-1:0];
		end else begin
			result = mag[m4inv_pkg::ELEM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= m4inv_pkg::ST_LOAD;
			phase_q     <= m4inv_pkg::PH_MINOR;
			load_cnt_q  <= '0;
			grp_q       <= '0;
			term_q      <= '0;
			limb_q      <= '0;
			drain_q     <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			op_s1       <= '0;
		end else begin
			state_q     <= state_d;
			op_s1.valid <= issue;
			op_s1.x     <= mat_a_q[xa];
			op_s1.y     <= y_sel;
			op_s1.limb  <= limb_q;
			op_s1.neg   <= op_neg;
			op_s1.last  <= op_last;
			op_s1.dst   <= '{kind: phase_q, idx: grp_q};
			if (in_valid && !in_stall) begin
				load_cnt_q <= load_cnt_q + 4'd1;
				if (load_cnt_q == 4'd15) begin
					phase_q <= m4inv_pkg::PH_MINOR;
					grp_q   <= '0;
					term_q  <= '0;
					limb_q  <= '0;
				end
			end
			if (issue) begin
				if (phase_end) begin
					grp_q   <= '0;
					term_q  <= '0;
					limb_q  <= '0;
					drain_q <= 3'(m4inv_pkg::DRAIN_CYC);
				end else if (limb_q == limb_max) begin
					limb_q <= '0;
					if (term_q == term_max) begin
						term_q <= '0;
						grp_q  <= grp_q + 4'd1;
					end else begin
						term_q <= term_q + 2'd1;
					end
				end else begin
					limb_q <= limb_q + 2'd1;
				end
			end
			if (state_q == m4inv_pkg::ST_DRAIN) begin
				drain_q <= drain_q - 3'd1;
				if (drain_q == 3'd0) begin
					k_q <= '0;
					if (phase_q == m4inv_pkg::PH_MINOR) begin
						phase_q <= m4inv_pkg::PH_COF;
					end else if (phase_q == m4inv_pkg::PH_COF) begin
						phase_q <= m4inv_pkg::PH_DET;
					end
				end
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				k_q         <= k_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mat_a_q[load_cnt_q] <= element_value;
			mat_b_q[load_cnt_q] <= element_value;
		end
		if (mac_res.valid) begin
			unique case (mac_res.dst.kind)
				m4inv_pkg::PH_MINOR: minor_q[mac_res.dst.idx] <=
					mac_res.value[m4inv_pkg::MINOR_W-1:0];
				m4inv_pkg::PH_COF:   cof_q[mac_res.dst.idx] <=
					mac_res.value[m4inv_pkg::COF_W-1:0];
				default:             det_q <= mac_res.value[m4inv_pkg::DET_W-1:0];
			endcase
		end
		if (state_q == m4inv_pkg::ST_DIV_START) begin
			neg_q <= cof_div[m4inv_pkg::COF_W-1] ^ det_q[m4inv_pkg::DET_W-1];
		end
		if (out_load) begin
			inverse_value_q <= result;
			singular_q      <= det_zero;
			last_q          <= (k_q == 4'd15);
		end
	end

	m4inv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_s1),
		.res    (mac_res)
	);

	m4inv_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (cof_abs[m4inv_pkg::CMAG_W-1:0]),
		.den_mag (det_abs[m4inv_pkg::DMAG_W-1:0]),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign out_valid     = out_valid_q;
	assign inverse_value = inverse_value_q;
	assign singular      = singular_q;
	assign last_element  = last_q;

`ifndef NO_ASSERTIONS
	a_mac_res_window: assert property (@(posedge clk) disable iff (!arst_n)
		mac_res.valid |-> (state_q == m4inv_pkg::ST_MAC || state_q == m4inv_pkg::ST_DRAIN))
		else $error("Accumulator result arrived outside the multiply phases.");

	a_div_done_window: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == m4inv_pkg::ST_DIV_WAIT)
		else $error("Divider finished while no division was awaited.");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && singular) |-> inverse_value == '0)
		else $error("Singular matrix produced a nonzero item.");

	a_start_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && load_cnt_q == 4'd15) |=> state_q == m4inv_pkg::ST_MAC)
		else $error("Sixteenth element did not start the multiply phase.");
`endif

endmodule
